/* hdl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// shared types and constants for the lru page replacement block
// ----------------------------------------------------------------------------
package lpr_pkg;

  // fault counter width and saturation value
  localparam int FAULT_W = 16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hffff;

  // width of the frame limit register
  localparam int LIMIT_W = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  // output queue occupancy, one-hot
  typedef enum logic [2:0] {
    ST_EMPTY = 3'b001,
    ST_ONE   = 3'b010,
    ST_TWO   = 3'b100
  } lpr_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic step;        // transaction accepted, update the stack
    logic load_out;    // new result into the output register
    logic load_spare;  // new result into the skid register
    logic move_spare;  // skid register into the output register
  } lpr_cmd_t;

endpackage

/* hdl/lpr_ctrl.sv */
// ----------------------------------------------------------------------------
// lpr_ctrl
// handshake controller: tracks the output register and the skid register
// ----------------------------------------------------------------------------
module lpr_ctrl
  import lpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output lpr_cmd_t cmd
);

  lpr_state_t state, state_next;
  logic       accept;
  logic       take;

  assign in_stall  = (state == ST_TWO);
  assign out_valid = (state != ST_EMPTY);
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.step       = accept;
    case (state)
      ST_EMPTY: begin
        if (accept) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ONE;
        end
      end
      ST_ONE: begin
        if (accept && take) begin
          cmd.load_out = 1'b1;
        end else if (accept) begin
          cmd.load_spare = 1'b1;
          state_next     = ST_TWO;
        end else if (take) begin
          state_next = ST_EMPTY;
        end
      end
      ST_TWO: begin
        if (take) begin
          cmd.move_spare = 1'b1;
          state_next     = ST_ONE;
        end
      end
      default: begin
        state_next = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TWO) |-> !cmd.step)
    else $error("transaction accepted with both result registers busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TWO && !out_stall) |=> (state == ST_ONE))
    else $error("skid register not moved forward");

endmodule

/* hdl/lpr_datapath.sv */
// ----------------------------------------------------------------------------
// lpr_datapath
// recency stack cells, fault counter, limit register and result registers
// ----------------------------------------------------------------------------
module lpr_datapath
  import lpr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lpr_cmd_t             cmd,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 restart,
  input  logic                 cfg_write,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output logic                 hit,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [FAULT_W-1:0]   fault_total
);

  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

  logic [PAGE_BITS-1:0] stack [FRAMES];
  logic [PAGE_BITS-1:0] stack_next [FRAMES];
  logic [OCC_W-1:0]     occupancy, occupancy_next;
  logic [FAULT_W-1:0]   fault_counter, fault_counter_next;
  logic [LIMIT_W-1:0]   frame_limit;

  logic                 spare_hit, spare_ev_valid;
  logic [PAGE_BITS-1:0] spare_ev_page;
  logic [FAULT_W-1:0]   spare_fault;

  logic [OCC_W-1:0]     occ_eff;
  logic [FAULT_W-1:0]   flt_eff;
  logic [FRAMES-1:0]    match;
  logic                 found;
  logic [OCC_W-1:0]     pos;
  logic [CMP_W-1:0]     lim;
  logic [CMP_W-1:0]     lim_raw;
  logic                 evict;
  logic [OCC_W-1:0]     top;
  logic [OCC_W-1:0]     last;
  logic [PAGE_BITS-1:0] ev_page;

  always_comb begin
    occ_eff = restart ? '0 : occupancy;
    flt_eff = restart ? '0 : fault_counter;

    // every cell compares in parallel, first match wins
    for (int k = 0; k < FRAMES; k++) begin
      match[k] = (OCC_W'(k) < occ_eff) && (stack[k] == page);
    end
    found = |match;
    pos   = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (match[k]) pos = OCC_W'(k);
    end

    lim_raw = CMP_W'(frame_limit);
    if (lim_raw == '0) begin
      lim = CMP_W'(1);
    end else if (lim_raw > CMP_W'(FRAMES)) begin
      lim = CMP_W'(FRAMES);
    end else begin
      lim = lim_raw;
    end

    evict   = !found && (CMP_W'(occ_eff) >= lim);
    last    = occ_eff - OCC_W'(1);
    ev_page = evict ? stack[last[IDX_W-1:0]] : '0;

    if (found) begin
      top = pos;
    end else if (evict) begin
      top = last;
    end else begin
      top = occ_eff;
    end

    // one-step shift toward the lru end, up to the hole at top
    for (int k = 0; k < FRAMES; k++) begin
      if (k == 0) begin
        stack_next[k] = page;
      end else if (OCC_W'(k) <= top) begin
        stack_next[k] = stack[k-1];
      end else begin
        stack_next[k] = stack[k];
      end
    end

    occupancy_next = (!found && !evict) ? occ_eff + OCC_W'(1) : occ_eff;
    if (found || flt_eff == FAULT_MAX) begin
      fault_counter_next = flt_eff;
    end else begin
      fault_counter_next = flt_eff + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      for (int k = 0; k < FRAMES; k++) begin
        stack[k] <= stack_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy     <= '0;
      fault_counter <= '0;
      frame_limit   <= LIMIT_RESET;
    end else begin
      if (cmd.step) begin
        occupancy     <= occupancy_next;
        fault_counter <= fault_counter_next;
      end
      if (cfg_write) begin
        frame_limit <= cfg_data;
      end
    end
  end

  // result registers, payload only
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit           <= found;
      evicted_valid <= evict;
      evicted_page  <= ev_page;
      fault_total   <= fault_counter_next;
    end else if (cmd.move_spare) begin
      hit           <= spare_hit;
      evicted_valid <= spare_ev_valid;
      evicted_page  <= spare_ev_page;
      fault_total   <= spare_fault;
    end
    if (cmd.load_spare) begin
      spare_hit      <= found;
      spare_ev_valid <= evict;
      spare_ev_page  <= ev_page;
      spare_fault    <= fault_counter_next;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(FRAMES))
    else $error("occupancy above frame count");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && found) |-> !evict)
    else $error("eviction on a hit");
  a_restart_fault: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && restart) |=> (fault_counter == FAULT_W'(1)))
    else $error("fault count after restart is not one");

endmodule

/* hdl/lru_page_replacement.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative lru page-frame tracker with saturating fault count
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction | handshake
//  ---------+----------------------------------+-----------+---------------
//  access   | page, restart                    | in        | in_valid/stall
//  result   | hit, evicted_valid, evicted_page,| out       | out_valid/stall
//           | fault_total                      |           |
//  config   | cfg_data (frame limit)           | in        | cfg_valid/ready
//
//  one access per cycle while in_stall is low: the compare in every
//  frame cell, the first-match select and the one-step stack shift
//  are all combinational, and the result is registered
//  a stalled result is kept in the output register; one more transaction
//  goes into a skid register, after that in_stall is raised
//  synchronous reset empties the stack, clears the fault count and sets
//  the frame limit to 8
//
module lru_page_replacement
  import lpr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // access channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 restart,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [FAULT_W-1:0]   fault_total,
  // frame limit write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  lpr_cmd_t cmd;

  // limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // handshake and result-queue control
  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // frame cells, counters and result registers
  lpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .page          (page),
    .restart       (restart),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule

/* sim/lru_page_replacement_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_replacement_tb
// self-checking bench: a queue-fed driver pushes page accesses, a shadow lru
// stack predicts each result and a monitor compares every result field
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
  import lpr_pkg::*;

  localparam int FRAMES_N   = 8;
  localparam int PAGE_W     = 16;
  localparam int MAX_CYCLES = 3_000_000;
  localparam int BURST_RUN  = 20;

  // one access transaction and one result transaction
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              restart;
  } access_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } lru_result_t;

  // dut ports, all inputs known from time zero
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [PAGE_W-1:0]  page      = '0;
  logic               restart   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data  = '0;

  // shadow copy of the tracker state, updated on every accepted access
  logic [PAGE_W-1:0]  lru_stack [FRAMES_N];
  int                 resident        = 0;
  logic [FAULT_W-1:0] fault_count     = '0;
  logic [LIMIT_W-1:0] frame_limit_reg = LIMIT_RESET;

  access_t     access_q [$];     // accesses waiting for the driver
  lru_result_t predicted_q [$];  // results owed by the dut, oldest first

  int errors    = 0;
  int cycles    = 0;
  int gap_left  = 0;
  int stall_left = 0;
  int drv_quiet = 0;
  int mon_quiet = 0;
  bit rush      = 1'b0;          // no idling on either side

  // random working set for the random phases
  logic [PAGE_W-1:0] hot_pages [16];
  int                hot_span = 1;

  lru_page_replacement #(
    .FRAMES   (FRAMES_N),
    .PAGE_BITS(PAGE_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .page         (page),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .fault_total  (fault_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // zero is taken as one frame, anything above the array as the full array
  function automatic int effective_frames();
    if (frame_limit_reg == 0) return 1;
    if (frame_limit_reg > FRAMES_N) return FRAMES_N;
    return int'(frame_limit_reg);
  endfunction

  // predict one access and advance the shadow stack
  function automatic lru_result_t lru_access(logic [PAGE_W-1:0] pg, logic rs);
    lru_result_t r;
    int          lim;
    int          pos;
    bit          found;
    lim   = effective_frames();
    r     = '0;
    found = 1'b0;
    pos   = 0;
    // restart empties the stack before the lookup
    if (rs) begin
      resident    = 0;
      fault_count = '0;
    end
    // search every resident page, even past a lowered limit
    for (int k = 0; k < resident; k++) begin
      if (!found && lru_stack[k] == pg) begin
        found = 1'b1;
        pos   = k;
      end
    end
    if (!found) begin
      if (fault_count != FAULT_MAX) fault_count = fault_count + 1'b1;
      if (resident >= lim) begin
        // full (or over the limit): drop the lru page, occupancy holds
        r.evicted_valid = 1'b1;
        r.evicted_page  = lru_stack[resident-1];
        pos             = resident - 1;
      end else begin
        pos      = resident;
        resident = resident + 1;
      end
    end
    // shift the younger pages down and put this page on top
    for (int k = pos; k > 0; k--) lru_stack[k] = lru_stack[k-1];
    lru_stack[0]  = pg;
    r.hit         = found;
    r.fault_total = fault_count;
    return r;
  endfunction

  // per transaction random wait, with quiet stretches of no idling
  function automatic int draw_wait(inout int quiet);
    if (rush) return 0;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("t=%0t %s: got %0h expected %0h", $time, what, got, want);
  endtask

  // access driver: predict on acceptance, then launch the next queued access
  always @(posedge clk) begin : access_driver
    access_t nxt;
    logic    nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        predicted_q.insert(predicted_q.size(), lru_access(page, restart));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() != 0) begin
          nxt = access_q.pop_front();
          page      <= nxt.page;
          restart   <= nxt.restart;
          nxt_valid = 1'b1;
          gap_left  = draw_wait(drv_quiet);
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // result monitor: field compare against the oldest prediction, random stall
  always @(posedge clk) begin : result_monitor
    lru_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("result with no access pending", 32'd1, 32'd0);
        end else begin
          want = predicted_q.pop_front();
          if (hit !== want.hit)
            report_mismatch("hit", 32'(hit), 32'(want.hit));
          if (evicted_valid !== want.evicted_valid)
            report_mismatch("evicted_valid", 32'(evicted_valid),
                            32'(want.evicted_valid));
          if (evicted_page !== want.evicted_page)
            report_mismatch("evicted_page", 32'(evicted_page),
                            32'(want.evicted_page));
          if (fault_total !== want.fault_total)
            report_mismatch("fault_total", 32'(fault_total), 32'(want.fault_total));
        end
        stall_left = draw_wait(mon_quiet);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_access(logic [PAGE_W-1:0] pg, logic rs);
    access_t a;
    a.page    = pg;
    a.restart = rs;
    access_q.insert(access_q.size(), a);
  endtask

  // sender holds off until every owed result is back, checked between edges
  task automatic wait_drained();
    do @(negedge clk);
    while (access_q.size() != 0 || in_valid || predicted_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // frame limit write, only called with the block idle
  task automatic write_limit(logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    frame_limit_reg = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly a small working set around the frame count, some far pages
  task automatic run_random_phase(int count, bit restart_first);
    logic [PAGE_W-1:0] pg;
    hot_span = effective_frames() + $urandom_range(1, 4);
    for (int k = 0; k < hot_span; k++) hot_pages[k] = PAGE_W'($urandom_range(0, 65535));
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85) pg = hot_pages[$urandom_range(0, hot_span - 1)];
      else pg = PAGE_W'($urandom_range(0, 65535));
      push_access(pg, (k == 0 && restart_first) || ($urandom_range(0, 49) == 0));
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limits [10];
    phase_limits = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd5, 4'd3, 4'd7, 4'd4};
    phase_limits[8] = LIMIT_W'($urandom_range(0, 15));
    phase_limits[9] = LIMIT_W'($urandom_range(0, 15));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limit of 8: fill, hit, evict, extreme page values
    push_access(16'h0000, 1'b0);
    push_access(16'hffff, 1'b0);
    push_access(16'h0000, 1'b0);
    push_access(16'h5555, 1'b0);
    push_access(16'haaaa, 1'b0);
    push_access(16'h0001, 1'b0);
    push_access(16'h8000, 1'b0);
    push_access(16'h1234, 1'b0);
    push_access(16'h00ff, 1'b0);
    push_access(16'h7fff, 1'b0);
    push_access(16'haaaa, 1'b0);
    wait_drained();

    // limit lowered below occupancy: misses replace the lru, deep hits still found
    write_limit(4'd3);
    push_access(16'h4444, 1'b0);
    push_access(16'h0001, 1'b0);
    push_access(16'h8000, 1'b0);
    // restart with a resident page still faults
    push_access(16'h4444, 1'b1);
    push_access(16'h4444, 1'b0);
    wait_drained();

    // single frame, then zero taken as one
    write_limit(4'd1);
    push_access(16'h0002, 1'b1);
    push_access(16'h0003, 1'b0);
    push_access(16'h0003, 1'b0);
    wait_drained();
    write_limit(4'd0);
    push_access(16'h0004, 1'b0);
    push_access(16'h0003, 1'b0);
    wait_drained();

    // limit above the array size behaves as the full array
    write_limit(4'd15);
    for (int k = 0; k < 9; k++) push_access(PAGE_W'(k + 16), k == 0);
    wait_drained();

    // back-to-back misses with no idling on either side
    write_limit(4'd1);
    rush = 1'b1;
    push_access(16'h0f0f, 1'b1);
    for (int k = 0; k < BURST_RUN; k++) push_access(k[0] ? 16'h0f0f : 16'hf0f0, 1'b0);
    wait_drained();
    rush = 1'b0;

    // random phases over a spread of limits, some without a leading restart
    for (int p = 0; p < 10; p++) begin
      write_limit(phase_limits[p]);
      run_random_phase(125, p[0]);
      wait_drained();
    end

    repeat (5) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
